// ----- rtl/core/pfcp_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pfcp_pkg - shared types and constants
// Event codes, message kinds, parser state and configuration structs.
// ============================================================================
package pfcp_pkg;

    localparam int unsigned PREAMBLE_LEN = 4;
    localparam int unsigned POS_W        = 4;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_MATCHED = 3'd1,
        EV_ABORT   = 3'd2,
        EV_RUN     = 3'd3,
        EV_OPEN    = 3'd4,
        EV_PAYLOAD = 3'd5,
        EV_COLOR   = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_RUN  = 2'd1,
        KIND_TEST = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_PREAMBLE  = 2'd0,
        CFG_RUN_CODE  = 2'd1,
        CFG_TEST_CODE = 2'd2
    } cfg_index_t;

    localparam logic [1:0] COLOR_RED   = 2'd0;
    localparam logic [1:0] COLOR_GREEN = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    localparam logic [1:0] LEN_LOW     = 2'd0;
    localparam logic [1:0] LEN_HIGH    = 2'd1;
    localparam logic [1:0] LEN_PAYLOAD = 2'd2;

    localparam logic [POS_W-1:0] POS_FULL = POS_W'(PREAMBLE_LEN);

    typedef struct packed {
        logic [31:0] preamble_bytes;
        logic [7:0]  run_type_code;
        logic [7:0]  test_type_code;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] match_position;
        kind_t            message_kind;
        logic [1:0]       color_phase;
        logic [7:0]       held_red;
        logic [7:0]       held_green;
        logic [1:0]       length_phase;
        logic [15:0]      bytes_remaining;
    } parse_state_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] payload_byte;
        logic       payload_last;
        logic [7:0] color_red;
        logic [7:0] color_green;
        logic [7:0] color_blue;
        logic       synced;
    } result_t;

endpackage

// ----- rtl/core/preamble_framed_command_parser_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// preamble_framed_command_parser_top - preamble framed command parser
// Deframes a byte stream into run payload bytes and test colour triples.
// ============================================================================
// Every accepted item yields exactly one result item. Items pass through an
// input register and a result register with combinational parser logic in
// between, so one item is taken per clock as long as the result side keeps
// up; the result register lets the next item enter while a finished result
// waits. The parser state updates when an item moves into the result
// register. Configuration is always ready, so every write is taken.
module preamble_framed_command_parser_top
    import pfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] rx_byte, [8] write_access_ok, zero fill
    input  logic        s_tuser,   // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] payload_byte, [15:8] color_red,
                                   // [23:16] color_green, [31:24] color_blue,
                                   // [32] synced, zero fill
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast,   // payload_last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t         cfg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_next;
    result_t      res_reg;

    logic         in_valid_reg;
    logic         in_func_reg;
    logic [7:0]   in_byte_reg;
    logic         in_grant_reg;
    logic         out_valid_reg;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    pfcp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pfcp_step u_step
    (
        .cfg             (cfg),
        .cur             (state_reg),
        .func            (in_func_reg),
        .rx_byte         (in_byte_reg),
        .write_access_ok (in_grant_reg),
        .nxt             (state_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_func_reg  <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_grant_reg <= s_tdata[8];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tlast  = res_reg.payload_last;
    assign m_tdata  = {7'd0, res_reg.synced, res_reg.color_blue, res_reg.color_green,
                       res_reg.color_red, res_reg.payload_byte};

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.match_position <= POS_FULL)
        else $error("match position beyond preamble");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == EV_PAYLOAD)
        else $error("last flag without payload event");

    a_matched_synced: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == EV_MATCHED |-> m_tdata[32])
        else $error("preamble match without synced");

    a_color_only_event: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != EV_COLOR |-> m_tdata[31:8] == 24'd0)
        else $error("colour fields set outside colour event");

    a_advance_state: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed without an item");

endmodule

// ----- rtl/core/pfcp_cfg_regs.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pfcp_cfg_regs - configuration register file
// Holds preamble and type codes; written through the index/data channel.
// ============================================================================
module pfcp_cfg_regs
    import pfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_PREAMBLE:  cfg_next.preamble_bytes = cfg_data;
                CFG_RUN_CODE:  cfg_next.run_type_code  = cfg_data[7:0];
                CFG_TEST_CODE: cfg_next.test_type_code = cfg_data[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_bytes <= 32'd0;
            cfg_reg.run_type_code  <= 8'd1;
            cfg_reg.test_type_code <= 8'd2;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- rtl/core/pfcp_step.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pfcp_step - per-item parser step
// Next parser state and result for one registered item.
// ============================================================================
module pfcp_step
    import pfcp_pkg::*;
(
    input  cfg_t         cfg,
    input  parse_state_t cur,
    input  logic         func,
    input  logic [7:0]   rx_byte,
    input  logic         write_access_ok,
    output parse_state_t nxt,
    output result_t      res
);

    logic [7:0]  expected;
    logic [15:0] remaining_dec;

    assign expected      = cfg.preamble_bytes[{cur.match_position[1:0], 3'b000} +: 8];
    assign remaining_dec = cur.bytes_remaining - 16'd1;

    always_comb
    begin
        nxt = cur;
        res = '0;
        res.event_res = EV_NONE;

        if (func)
        begin
            nxt.match_position = '0;
        end
        else if (cur.match_position < POS_FULL)
        begin
            if (rx_byte == expected)
            begin
                nxt.match_position = cur.match_position + POS_W'(1);
                if (nxt.match_position == POS_FULL)
                begin
                    nxt.message_kind = KIND_NONE;
                    res.event_res    = EV_MATCHED;
                end
            end
            else
            begin
                nxt.match_position = '0;
                nxt.message_kind   = KIND_NONE;
            end
        end
        else if (cur.match_position > POS_FULL)
        begin
            nxt.match_position = '0;
        end
        else
        begin
            case (cur.message_kind)
                KIND_NONE:
                begin
                    if (rx_byte == cfg.run_type_code)
                    begin
                        if (write_access_ok)
                        begin
                            nxt.message_kind = KIND_RUN;
                            nxt.length_phase = LEN_LOW;
                            res.event_res    = EV_RUN;
                        end
                        else
                        begin
                            nxt.match_position = '0;
                            res.event_res      = EV_ABORT;
                        end
                    end
                    else if (rx_byte == cfg.test_type_code)
                    begin
                        nxt.message_kind = KIND_TEST;
                        nxt.color_phase  = COLOR_RED;
                    end
                    else
                    begin
                        nxt.match_position = '0;
                        res.event_res      = EV_ABORT;
                    end
                end
                KIND_TEST:
                begin
                    case (cur.color_phase)
                        COLOR_RED:
                        begin
                            nxt.held_red    = rx_byte;
                            nxt.color_phase = COLOR_GREEN;
                        end
                        COLOR_GREEN:
                        begin
                            nxt.held_green  = rx_byte;
                            nxt.color_phase = COLOR_BLUE;
                        end
                        COLOR_BLUE:
                        begin
                            res.color_red      = cur.held_red;
                            res.color_green    = cur.held_green;
                            res.color_blue     = rx_byte;
                            res.event_res      = EV_COLOR;
                            nxt.match_position = '0;
                            nxt.message_kind   = KIND_NONE;
                        end
                        default:
                        begin
                            nxt.match_position = '0;
                            nxt.message_kind   = KIND_NONE;
                            res.event_res      = EV_ABORT;
                        end
                    endcase
                end
                KIND_RUN:
                begin
                    case (cur.length_phase)
                        LEN_LOW:
                        begin
                            nxt.bytes_remaining = {8'd0, rx_byte};
                            nxt.length_phase    = LEN_HIGH;
                            res.event_res       = EV_OPEN;
                        end
                        LEN_HIGH:
                        begin
                            nxt.bytes_remaining = {rx_byte, cur.bytes_remaining[7:0]};
                            nxt.length_phase    = LEN_PAYLOAD;
                        end
                        LEN_PAYLOAD:
                        begin
                            // zero length wraps, giving 65536 bytes
                            res.payload_byte    = rx_byte;
                            res.event_res       = EV_PAYLOAD;
                            nxt.bytes_remaining = remaining_dec;
                            if (remaining_dec == 16'd0)
                            begin
                                res.payload_last   = 1'b1;
                                nxt.match_position = '0;
                                nxt.message_kind   = KIND_NONE;
                            end
                        end
                        default:
                        begin
                            nxt.match_position = '0;
                            nxt.message_kind   = KIND_NONE;
                            res.event_res      = EV_ABORT;
                        end
                    endcase
                end
                default:
                begin
                    nxt.match_position = '0;
                    nxt.message_kind   = KIND_NONE;
                    res.event_res      = EV_ABORT;
                end
            endcase
        end

        res.synced = (nxt.match_position == POS_FULL);
    end

endmodule

// ----- tb/sv/tb_preamble_framed_command_parser_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_preamble_framed_command_parser_top - self-checking parser testbench
// Feeds framed byte streams (good frames, broken frames, receiver resets,
// noise) under several preamble and type-code settings, predicts every
// result item with an in-bench parser model and checks each output field.
// ============================================================================
module tb_preamble_framed_command_parser_top;
    import pfcp_pkg::*;

    typedef struct packed {
        logic       func;
        logic [7:0] rx;
        logic       grant;
    } rx_item_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = CFG_PREAMBLE;
    logic [31:0] cfg_data = '0;

    preamble_framed_command_parser_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rx_item_t rx_items[$];
    result_t  pending_results[$];
    rx_item_t drv_item;

    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 72;
    int unsigned items_queued = 0;
    int unsigned fail_count = 0;
    int unsigned n_accepted = 0;
    int unsigned n_results = 0;
    int unsigned n_payload = 0;
    int unsigned n_colors = 0;
    int unsigned n_aborts = 0;
    int unsigned n_cfg_writes = 0;

    // settings the stimulus generator builds frames from
    logic [31:0] gen_preamble = '0;
    logic [7:0]  gen_run = 8'd1;
    logic [7:0]  gen_test = 8'd2;

    // parser model: configuration and state
    logic [31:0]      cur_preamble = '0;
    logic [7:0]       cur_run_code = 8'd1;
    logic [7:0]       cur_test_code = 8'd2;
    logic [POS_W-1:0] pos = '0;
    kind_t            kind = KIND_NONE;
    logic [1:0]       col_phase = COLOR_RED;
    logic [7:0]       red_hold = '0;
    logic [7:0]       green_hold = '0;
    logic [1:0]       len_phase = LEN_LOW;
    logic [15:0]      remaining = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void drop_frame();
        pos  = '0;
        kind = KIND_NONE;
    endfunction

    function automatic result_t parse_byte(input logic func, input logic [7:0] rx,
                                           input logic grant);
        result_t r;
        r = '0;
        r.event_res = EV_NONE;
        if (func)
            pos = '0;
        else if (pos < POS_FULL)
        begin
            if (rx == cur_preamble[8*pos[1:0] +: 8])
            begin
                pos = pos + POS_W'(1);
                if (pos == POS_FULL)
                begin
                    kind = KIND_NONE;
                    r.event_res = EV_MATCHED;
                end
            end
            else
                drop_frame();
        end
        else if (pos > POS_FULL)
            pos = '0;
        else if (kind == KIND_NONE)
        begin
            if (rx == cur_run_code)
            begin
                if (grant)
                begin
                    kind = KIND_RUN;
                    len_phase = LEN_LOW;
                    r.event_res = EV_RUN;
                end
                else
                begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            end
            else if (rx == cur_test_code)
            begin
                kind = KIND_TEST;
                col_phase = COLOR_RED;
            end
            else
            begin
                drop_frame();
                r.event_res = EV_ABORT;
            end
        end
        else if (kind == KIND_TEST)
        begin
            case (col_phase)
                COLOR_RED:
                begin
                    red_hold = rx;
                    col_phase = COLOR_GREEN;
                end
                COLOR_GREEN:
                begin
                    green_hold = rx;
                    col_phase = COLOR_BLUE;
                end
                COLOR_BLUE:
                begin
                    r.color_red = red_hold;
                    r.color_green = green_hold;
                    r.color_blue = rx;
                    r.event_res = EV_COLOR;
                    drop_frame();
                end
                default:
                begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            endcase
        end
        else if (kind == KIND_RUN)
        begin
            case (len_phase)
                LEN_LOW:
                begin
                    remaining = {8'd0, rx};
                    len_phase = LEN_HIGH;
                    r.event_res = EV_OPEN;
                end
                LEN_HIGH:
                begin
                    remaining = remaining | {rx, 8'd0};
                    len_phase = LEN_PAYLOAD;
                end
                LEN_PAYLOAD:
                begin
                    r.payload_byte = rx;
                    r.event_res = EV_PAYLOAD;
                    remaining = remaining - 16'd1;
                    if (remaining == 16'd0)
                    begin
                        r.payload_last = 1'b1;
                        drop_frame();
                    end
                end
                default:
                begin
                    drop_frame();
                    r.event_res = EV_ABORT;
                end
            endcase
        end
        else
        begin
            drop_frame();
            r.event_res = EV_ABORT;
        end
        r.synced = (pos == POS_FULL);
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (rx_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                drv_item = rx_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, drv_item.grant, drv_item.rx};
                s_tuser  <= drv_item.func;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checking, then prediction of newly accepted items
    always @(posedge clk)
    begin : scoreboard
        result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                case (m_tuser)
                    EV_PAYLOAD: n_payload++;
                    EV_COLOR:   n_colors++;
                    EV_ABORT:   n_aborts++;
                    default:    ;
                endcase
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expected result: event %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("event_res", 16'(want.event_res), 16'(m_tuser));
                    check_field("payload_byte", 16'(want.payload_byte), 16'(m_tdata[7:0]));
                    check_field("payload_last", 16'(want.payload_last), 16'(m_tlast));
                    check_field("color_red", 16'(want.color_red), 16'(m_tdata[15:8]));
                    check_field("color_green", 16'(want.color_green), 16'(m_tdata[23:16]));
                    check_field("color_blue", 16'(want.color_blue), 16'(m_tdata[31:24]));
                    check_field("synced", 16'(want.synced), 16'(m_tdata[32]));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                n_cfg_writes++;
                case (cfg_index)
                    CFG_PREAMBLE:  cur_preamble = cfg_data;
                    CFG_RUN_CODE:  cur_run_code = cfg_data[7:0];
                    CFG_TEST_CODE: cur_test_code = cfg_data[7:0];
                    default:       ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                n_accepted++;
                pending_results.push_back(parse_byte(s_tuser, s_tdata[7:0], s_tdata[8]));
            end
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_PREAMBLE:  gen_preamble = val;
            CFG_RUN_CODE:  gen_run = val[7:0];
            CFG_TEST_CODE: gen_test = val[7:0];
            default:       ;
        endcase
    endtask

    task automatic configure(input logic [31:0] preamble, input logic [7:0] run_code,
                             input logic [7:0] test_code);
        write_reg(CFG_PREAMBLE, preamble);
        write_reg(CFG_RUN_CODE, {24'd0, run_code});
        write_reg(CFG_TEST_CODE, {24'd0, test_code});
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (rx_items.size() > 0 || s_tvalid || pending_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_item(input logic func, input logic [7:0] rx, input logic grant);
        rx_items.push_back('{func, rx, grant});
        items_queued++;
    endtask

    task automatic push_rand_byte();
        push_item(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    task automatic push_preamble(input int unsigned n);
        for (int i = 0; i < n; i++)
            push_item(1'b0, gen_preamble[8*i +: 8], 1'($urandom_range(1)));
    endtask

    task automatic push_run(input logic grant, input logic [15:0] len);
        int unsigned n;
        n = (len == 16'd0) ? 32'd65536 : 32'(len);
        push_preamble(PREAMBLE_LEN);
        push_item(1'b0, gen_run, grant);
        if (grant)
        begin
            push_item(1'b0, len[7:0], 1'($urandom_range(1)));
            push_item(1'b0, len[15:8], 1'($urandom_range(1)));
            for (int i = 0; i < n; i++)
                push_rand_byte();
        end
    endtask

    task automatic push_test();
        push_preamble(PREAMBLE_LEN);
        push_item(1'b0, gen_test, 1'($urandom_range(1)));
        repeat (3) push_rand_byte();
    endtask

    function automatic logic [15:0] pick_len();
        if ($urandom_range(49) == 0)
            return 16'($urandom_range(256, 300));
        else if ($urandom_range(9) < 7)
            return 16'($urandom_range(1, 6));
        else
            return 16'($urandom_range(7, 40));
    endfunction

    task automatic random_frames(input int unsigned target);
        int unsigned start;
        int unsigned sel;
        logic [7:0]  odd_code;
        start = items_queued;
        while (items_queued - start < target)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                push_run(1'b1, pick_len());
            else if (sel < 65)
                push_test();
            else if (sel < 71)
                push_run(1'b0, '0);
            else if (sel < 77)
            begin
                do
                    odd_code = 8'($urandom_range(255));
                while (odd_code == gen_run || odd_code == gen_test);
                push_preamble(PREAMBLE_LEN);
                push_item(1'b0, odd_code, 1'($urandom_range(1)));
            end
            else if (sel < 84)
            begin
                push_preamble($urandom_range(0, PREAMBLE_LEN - 1));
                push_rand_byte();
            end
            else if (sel < 91)
            begin
                // receiver reset inside a frame, then a fresh frame
                if ($urandom_range(1))
                begin
                    push_preamble(PREAMBLE_LEN);
                    push_item(1'b0, gen_test, 1'($urandom_range(1)));
                    push_rand_byte();
                end
                else
                begin
                    push_preamble(PREAMBLE_LEN);
                    push_item(1'b0, gen_run, 1'b1);
                    push_item(1'b0, 8'd5, 1'($urandom_range(1)));
                    push_item(1'b0, 8'd0, 1'($urandom_range(1)));
                    push_rand_byte();
                end
                push_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
                if ($urandom_range(1))
                    push_test();
                else
                    push_run(1'b1, pick_len());
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_item(1'($urandom_range(7) == 0), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
        end
    endtask

    initial
    begin : stimulus
        logic [7:0] run_code;
        logic [7:0] test_code;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: all-zero preamble, run 1, test 2
        send_idle_pct = 21;
        recv_idle_pct = 72;
        push_item(1'b1, 8'hFF, 1'b1);
        push_item(1'b0, 8'h80, 1'b1);
        push_preamble(PREAMBLE_LEN);
        push_item(1'b0, 8'hFF, 1'b1);
        push_preamble(PREAMBLE_LEN);
        push_item(1'b0, gen_test, 1'b0);
        push_item(1'b0, 8'h00, 1'b0);
        push_item(1'b0, 8'hFF, 1'b1);
        push_item(1'b0, 8'h5A, 1'b0);
        push_run(1'b0, '0);
        push_run(1'b1, 16'd1);
        wait_idle();

        run_code = 8'($urandom_range(255));
        do
            test_code = 8'($urandom_range(255));
        while (test_code == run_code);
        configure($urandom, run_code, test_code);
        random_frames(250);
        wait_idle();
        random_frames(250);
        wait_idle();

        send_idle_pct = 72;
        recv_idle_pct = 21;
        configure(32'hFFFF_FFFF, 8'h00, 8'hFF);
        random_frames(450);
        wait_idle();
        run_code = 8'($urandom_range(255));
        configure($urandom, run_code, run_code);
        random_frames(350);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(32'h0000_0000, 8'hFF, 8'h00);
        random_frames(450);
        // zero length run: no byte may be marked last early; cut by receiver reset
        push_preamble(PREAMBLE_LEN);
        push_item(1'b0, gen_run, 1'b1);
        push_item(1'b0, 8'd0, 1'($urandom_range(1)));
        push_item(1'b0, 8'd0, 1'($urandom_range(1)));
        repeat (40) push_rand_byte();
        push_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
        random_frames(20);
        wait_idle();

        $display("Run covered %0d items, %0d results, %0d register writes.",
                 n_accepted, n_results, n_cfg_writes);
        $display("Results seen: %0d payload bytes, %0d colours, %0d aborted frames.",
                 n_payload, n_colors, n_aborts);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
